// File: src/bpl_pkg.sv
package bpl_pkg;

  // List capacity, a count width derived from it, and fixed field widths.
  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int COUNT_W = 6;

  // Operation requested by an input item.
  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_BACK  = 3'd1,
    K_INS_POS   = 3'd2,
    K_REM_FRONT = 3'd3,
    K_REM_BACK  = 3'd4,
    K_REM_POS   = 3'd5,
    K_COUNT     = 3'd6,
    K_LIST      = 3'd7
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // What a cell loads at the next clock edge.
  typedef enum logic [2:0] {
    C_HOLD,
    C_LOAD,
    C_FROM_LEFT,
    C_FROM_RIGHT,
    C_FROM_HEAD
  } cell_op_t;

  // Controller state.
  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  // Control sent from the controller to the row of cells.
  typedef struct packed {
    cell_op_t [DEPTH-1:0]    op;
    logic signed [VAL_W-1:0] din;
  } cell_ctl_t;

endpackage

// File: src/bounded_positional_list_top.sv
// Each result is registered at the edge that accepts its item.
// Throughput: one item per cycle for insert, remove and count while not busy; a list of N
// elements holds busy after acceptance until its final result and gives N
// results on consecutive cycles, set by rotating the cell row once per element.
// Reset (rst, synchronous) empties the list; results cannot be stalled.
module bounded_positional_list_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         kind,
  input  logic signed [bpl_pkg::VAL_W-1:0]   value,
  input  logic [bpl_pkg::POS_W-1:0]          position,
  output logic                               result_valid,
  output logic [1:0]                         status,
  output logic [bpl_pkg::COUNT_W-1:0]        count,
  output logic signed [bpl_pkg::VAL_W-1:0]   element,
  output logic                               element_valid,
  output logic                               last
);

  bpl_pkg::cell_ctl_t ctl;
  logic signed [bpl_pkg::VAL_W-1:0] q [bpl_pkg::DEPTH];

  // Controller with result registers.
  bpl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .value         (value),
    .position      (position),
    .head          (q[0]),
    .ctl           (ctl),
    .busy          (busy),
    .result_valid  (result_valid),
    .status        (status),
    .count         (count),
    .element       (element),
    .element_valid (element_valid),
    .last          (last)
  );

  // Row of cells; the ends see zero beyond the chain.
  for (genvar g = 0; g < bpl_pkg::DEPTH; g++) begin : g_cell
    logic signed [bpl_pkg::VAL_W-1:0] left_v;
    logic signed [bpl_pkg::VAL_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = q[g-1];
    end

    if (g == bpl_pkg::DEPTH - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = q[g+1];
    end

    bpl_cell u_cell (
      .clk   (clk),
      .op    (ctl.op[g]),
      .din   (ctl.din),
      .left  (left_v),
      .right (right_v),
      .head  (q[0]),
      .q     (q[g])
    );
  end

  // A single-result item always gives exactly one final result next cycle.
  a_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind != bpl_pkg::K_LIST) |=> (result_valid && last))
    else $error("single-result item did not produce a final result");

  // While listing, an element goes out every cycle.
  a_list_stream: assert property (@(posedge clk) disable iff (rst)
    busy |=> (result_valid && element_valid))
    else $error("listing cycle produced no element");

  // A result without an element is always the final one.
  a_novalid_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !element_valid) |-> last)
    else $error("non-element result not marked last");

  // Listing ends only with the final element.
  a_list_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (result_valid && last))
    else $error("listing ended without a final result");

endmodule

// File: src/bpl_cell.sv
module bpl_cell (
  input  logic                            clk,
  input  bpl_pkg::cell_op_t               op,
  input  logic signed [bpl_pkg::VAL_W-1:0] din,
  input  logic signed [bpl_pkg::VAL_W-1:0] left,
  input  logic signed [bpl_pkg::VAL_W-1:0] right,
  input  logic signed [bpl_pkg::VAL_W-1:0] head,
  output logic signed [bpl_pkg::VAL_W-1:0] q
);

  // One list slot: loads a new value, a neighbor's value or the head value, or holds.
  always_ff @(posedge clk) begin
    case (op)
      bpl_pkg::C_LOAD:       q <= din;
      bpl_pkg::C_FROM_LEFT:  q <= left;
      bpl_pkg::C_FROM_RIGHT: q <= right;
      bpl_pkg::C_FROM_HEAD:  q <= head;
      default:               q <= q;
    endcase
  end

endmodule

// File: src/bpl_ctrl.sv
module bpl_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [2:0]                         kind,
  input  logic signed [bpl_pkg::VAL_W-1:0]   value,
  input  logic [bpl_pkg::POS_W-1:0]          position,
  input  logic signed [bpl_pkg::VAL_W-1:0]   head,
  output bpl_pkg::cell_ctl_t                 ctl,
  output logic                               busy,
  output logic                               result_valid,
  output logic [1:0]                         status,
  output logic [bpl_pkg::COUNT_W-1:0]        count,
  output logic signed [bpl_pkg::VAL_W-1:0]   element,
  output logic                               element_valid,
  output logic                               last
);

  bpl_pkg::state_t state, state_next;
  logic [bpl_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [bpl_pkg::CNT_W-1:0] lidx, lidx_next;

  logic                               result_valid_next;
  bpl_pkg::status_t                   status_next;
  logic signed [bpl_pkg::VAL_W-1:0]   element_next;
  logic                               element_valid_next;
  logic                               last_next;

  logic                        accept;
  logic [bpl_pkg::POS_W:0]     pos_x;
  logic [bpl_pkg::POS_W:0]     cnt_x;
  logic [bpl_pkg::CNT_W-1:0]   pos_idx;
  logic [bpl_pkg::CNT_W-1:0]   cnt_m1;
  logic [bpl_pkg::CNT_W-1:0]   ins_idx;
  logic [bpl_pkg::CNT_W-1:0]   rem_idx;
  logic                        do_ins;
  logic                        do_rem;
  logic                        do_rot;

  assign busy = (state == bpl_pkg::S_LIST);
  assign accept = start && (state == bpl_pkg::S_IDLE);
  assign pos_x = {1'b0, position};
  assign cnt_x = (bpl_pkg::POS_W + 1)'(cnt);
  assign pos_idx = bpl_pkg::CNT_W'(position - bpl_pkg::POS_W'(1));
  assign cnt_m1 = cnt - bpl_pkg::CNT_W'(1);

  // Decode the item or step the listing, update the count and pick the result fields.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    lidx_next = lidx;
    result_valid_next = 1'b0;
    status_next = bpl_pkg::ST_DONE;
    element_next = '0;
    element_valid_next = 1'b0;
    last_next = 1'b0;
    ins_idx = '0;
    rem_idx = '0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_rot = 1'b0;

    if (state == bpl_pkg::S_LIST) begin
      // Listing: emit the head and rotate the list by one place.
      do_rot = 1'b1;
      result_valid_next = 1'b1;
      element_next = head;
      element_valid_next = 1'b1;
      last_next = (lidx == cnt_m1);
      lidx_next = lidx + bpl_pkg::CNT_W'(1);
      if (lidx == cnt_m1) begin
        state_next = bpl_pkg::S_IDLE;
      end
    end else if (accept) begin
      result_valid_next = 1'b1;
      last_next = 1'b1;
      case (bpl_pkg::kind_t'(kind))
        bpl_pkg::K_INS_FRONT, bpl_pkg::K_INS_BACK, bpl_pkg::K_INS_POS: begin
          if (cnt == bpl_pkg::CNT_W'(bpl_pkg::DEPTH)) begin
            status_next = bpl_pkg::ST_FULL;
          end else if (bpl_pkg::kind_t'(kind) == bpl_pkg::K_INS_FRONT) begin
            do_ins = 1'b1;
          end else if (bpl_pkg::kind_t'(kind) == bpl_pkg::K_INS_BACK) begin
            do_ins = 1'b1;
            ins_idx = cnt;
          end else if (position == '0 ||
                       pos_x > cnt_x + (bpl_pkg::POS_W + 1)'(1)) begin
            status_next = bpl_pkg::ST_BAD_POS;
          end else begin
            do_ins = 1'b1;
            ins_idx = pos_idx;
          end
          if (do_ins) begin
            cnt_next = cnt + bpl_pkg::CNT_W'(1);
          end
        end
        bpl_pkg::K_REM_FRONT, bpl_pkg::K_REM_BACK, bpl_pkg::K_REM_POS: begin
          if (cnt == '0) begin
            status_next = bpl_pkg::ST_EMPTY;
          end else if (bpl_pkg::kind_t'(kind) == bpl_pkg::K_REM_FRONT) begin
            do_rem = 1'b1;
          end else if (bpl_pkg::kind_t'(kind) == bpl_pkg::K_REM_BACK) begin
            do_rem = 1'b1;
            rem_idx = cnt_m1;
          end else if (position == '0 || pos_x > cnt_x) begin
            status_next = bpl_pkg::ST_BAD_POS;
          end else begin
            do_rem = 1'b1;
            rem_idx = pos_idx;
          end
          if (do_rem) begin
            cnt_next = cnt_m1;
          end
        end
        bpl_pkg::K_LIST: begin
          if (cnt != '0) begin
            // First element goes out now; the rest follow one per cycle.
            do_rot = 1'b1;
            element_next = head;
            element_valid_next = 1'b1;
            last_next = (cnt == bpl_pkg::CNT_W'(1));
            lidx_next = bpl_pkg::CNT_W'(1);
            if (cnt != bpl_pkg::CNT_W'(1)) begin
              state_next = bpl_pkg::S_LIST;
            end
          end
        end
        default: begin
          // Count report: nothing changes.
        end
      endcase
    end
  end

  // Per-cell shift selects, all cells decided side by side.
  always_comb begin
    ctl.din = value;
    for (int i = 0; i < bpl_pkg::DEPTH; i++) begin
      ctl.op[i] = bpl_pkg::C_HOLD;
      if (do_ins) begin
        if (bpl_pkg::CNT_W'(i) > ins_idx) begin
          ctl.op[i] = bpl_pkg::C_FROM_LEFT;
        end else if (bpl_pkg::CNT_W'(i) == ins_idx) begin
          ctl.op[i] = bpl_pkg::C_LOAD;
        end
      end else if (do_rem) begin
        if (bpl_pkg::CNT_W'(i) >= rem_idx) begin
          ctl.op[i] = bpl_pkg::C_FROM_RIGHT;
        end
      end else if (do_rot) begin
        if (bpl_pkg::CNT_W'(i) < cnt_m1) begin
          ctl.op[i] = bpl_pkg::C_FROM_RIGHT;
        end else if (bpl_pkg::CNT_W'(i) == cnt_m1) begin
          ctl.op[i] = bpl_pkg::C_FROM_HEAD;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpl_pkg::S_IDLE;
      cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      result_valid <= result_valid_next;
    end
  end

  // Result payload and listing index.
  always_ff @(posedge clk) begin
    lidx <= lidx_next;
    status <= status_next;
    count <= bpl_pkg::COUNT_W'(cnt_next);
    element <= element_next;
    element_valid <= element_valid_next;
    last <= last_next;
  end

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 330;
  localparam int REPORT_LIMIT = 10;
  localparam logic signed [bpl_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [bpl_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // One result as the block should present it.
  typedef struct {
    bpl_pkg::status_t                 st;
    logic [bpl_pkg::COUNT_W-1:0]      cnt;
    logic signed [bpl_pkg::VAL_W-1:0] elem;
    logic                             elem_valid;
    logic                             is_last;
  } list_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic                               busy;
  logic [2:0]                         kind = bpl_pkg::K_COUNT;
  logic signed [bpl_pkg::VAL_W-1:0]   value = '0;
  logic [bpl_pkg::POS_W-1:0]          position = '0;
  logic                               result_valid;
  logic [1:0]                         status;
  logic [bpl_pkg::COUNT_W-1:0]        count;
  logic signed [bpl_pkg::VAL_W-1:0]   element;
  logic                               element_valid;
  logic                               last;

  // Shadow copy of the list contents and the results still to come.
  logic signed [bpl_pkg::VAL_W-1:0] held_values[$];
  list_result_t                     pending_results[$];
  int                               mismatch_count = 0;
  int                               cycle_count = 0;

  bounded_positional_list_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .value        (value),
    .position     (position),
    .result_valid (result_valid),
    .status       (status),
    .count        (count),
    .element      (element),
    .element_valid(element_valid),
    .last         (last)
  );

  always #6 clk = ~clk;

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // Apply one accepted item to the shadow list and queue the results it causes.
  function automatic void predict_list_op(bpl_pkg::kind_t k,
                                          logic signed [bpl_pkg::VAL_W-1:0] v,
                                          logic [bpl_pkg::POS_W-1:0] p);
    list_result_t r;
    int n;
    int pos;
    n = held_values.size();
    pos = int'(p);
    r.st = bpl_pkg::ST_DONE;
    r.elem = '0;
    r.elem_valid = 1'b0;
    r.is_last = 1'b1;
    case (k)
      bpl_pkg::K_INS_FRONT, bpl_pkg::K_INS_BACK, bpl_pkg::K_INS_POS: begin
        // A full list refuses every insert before the position is looked at.
        if (n >= bpl_pkg::DEPTH) begin
          r.st = bpl_pkg::ST_FULL;
        end else if (k == bpl_pkg::K_INS_FRONT) begin
          held_values.push_front(v);
        end else if (k == bpl_pkg::K_INS_BACK) begin
          held_values.push_back(v);
        end else if (pos < 1 || pos > n + 1) begin
          r.st = bpl_pkg::ST_BAD_POS;
        end else begin
          held_values.insert(pos - 1, v);
        end
      end
      bpl_pkg::K_REM_FRONT, bpl_pkg::K_REM_BACK, bpl_pkg::K_REM_POS: begin
        // An empty list reports empty even when the position is also bad.
        if (n == 0) begin
          r.st = bpl_pkg::ST_EMPTY;
        end else if (k == bpl_pkg::K_REM_FRONT) begin
          held_values.delete(0);
        end else if (k == bpl_pkg::K_REM_BACK) begin
          held_values.delete(n - 1);
        end else if (pos < 1 || pos > n) begin
          r.st = bpl_pkg::ST_BAD_POS;
        end else begin
          held_values.delete(pos - 1);
        end
      end
      bpl_pkg::K_LIST: begin
        // Listing gives one result per element, or one invalid result if empty.
        if (n > 0) begin
          for (int i = 0; i < n; i++) begin
            r.cnt = bpl_pkg::COUNT_W'(n);
            r.elem = held_values[i];
            r.elem_valid = 1'b1;
            r.is_last = (i == n - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: begin
      end
    endcase
    r.cnt = bpl_pkg::COUNT_W'(held_values.size());
    pending_results.push_back(r);
  endfunction

  // Check every strobed result against the oldest expectation.
  always @(posedge clk) begin
    list_result_t e;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result st=%0d cnt=%0d elem=%0d ev=%0b last=%0b",
                                status, count, element, element_valid, last));
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st || count !== e.cnt || element !== e.elem ||
            element_valid !== e.elem_valid || last !== e.is_last) begin
          note_mismatch({
            $sformatf("exp st=%0d cnt=%0d elem=%0d ev=%0b last=%0b",
                      e.st, e.cnt, e.elem, e.elem_valid, e.is_last),
            $sformatf(", got st=%0d cnt=%0d elem=%0d ev=%0b last=%0b",
                      status, count, element, element_valid, last)});
        end
      end
    end
  end

  // Present one item and wait for the edge that accepts it; start stays high.
  task automatic send_item(input bpl_pkg::kind_t k,
                           input logic signed [bpl_pkg::VAL_W-1:0] v,
                           input logic [bpl_pkg::POS_W-1:0] p);
    kind <= k;
    value <= v;
    position <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_list_op(k, v, p);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic logic signed [bpl_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Grow mode favors inserts, otherwise removes dominate.
  function automatic bpl_pkg::kind_t pick_kind(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return bpl_pkg::K_COUNT;
    if (r < 13) return bpl_pkg::K_LIST;
    r = $urandom_range(0, 99);
    if ((grow && r < 70) || (!grow && r < 30)) begin
      case ($urandom_range(0, 2))
        0: return bpl_pkg::K_INS_FRONT;
        1: return bpl_pkg::K_INS_BACK;
        default: return bpl_pkg::K_INS_POS;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return bpl_pkg::K_REM_FRONT;
      1: return bpl_pkg::K_REM_BACK;
      default: return bpl_pkg::K_REM_POS;
    endcase
  endfunction

  // Mostly legal positions, some just outside the range, a few anywhere.
  function automatic logic [bpl_pkg::POS_W-1:0] pick_position(bpl_pkg::kind_t k);
    int n;
    int top;
    n = held_values.size();
    top = (k == bpl_pkg::K_INS_POS) ? n + 1 : n;
    case ($urandom_range(0, 9))
      8: return ($urandom_range(0, 1) == 0) ? bpl_pkg::POS_W'(0)
                                            : bpl_pkg::POS_W'(top + 1);
      9: return bpl_pkg::POS_W'($urandom_range(0, 127));
      default: return bpl_pkg::POS_W'($urandom_range(1, (top < 1) ? 1 : top));
    endcase
  endfunction

  // Every remove, the count and the listing on an empty list.
  task automatic test_empty_list();
    send_item(bpl_pkg::K_LIST, '0, '0);
    send_item(bpl_pkg::K_COUNT, '0, '0);
    send_item(bpl_pkg::K_REM_FRONT, '0, '0);
    send_item(bpl_pkg::K_REM_BACK, '0, '0);
    send_item(bpl_pkg::K_REM_POS, '0, 7'd0);
    send_item(bpl_pkg::K_REM_POS, '0, 7'd1);
  endtask

  // Position limits on both sides for inserts and removes, with extreme values.
  task automatic test_position_edges();
    send_item(bpl_pkg::K_INS_POS, 32'sd11, 7'd0);
    send_item(bpl_pkg::K_INS_POS, 32'sd12, 7'd2);
    send_item(bpl_pkg::K_INS_POS, VAL_MIN, 7'd1);
    send_item(bpl_pkg::K_INS_FRONT, VAL_MAX, '0);
    send_item(bpl_pkg::K_INS_BACK, -1, '0);
    send_item(bpl_pkg::K_INS_BACK, '0, '0);
    send_item(bpl_pkg::K_INS_POS, 32'sh5555_5555, 7'd5);
    send_item(bpl_pkg::K_INS_POS, 32'sh2aaa_aaaa, 7'd127);
    pause_sender(2);
    send_item(bpl_pkg::K_LIST, '0, '0);
    send_item(bpl_pkg::K_REM_POS, '0, 7'd0);
    send_item(bpl_pkg::K_REM_POS, '0, 7'd6);
    send_item(bpl_pkg::K_REM_POS, '0, 7'd127);
    send_item(bpl_pkg::K_REM_POS, '0, 7'd3);
    send_item(bpl_pkg::K_REM_FRONT, '0, '0);
    send_item(bpl_pkg::K_REM_BACK, '0, '0);
    send_item(bpl_pkg::K_COUNT, '0, '0);
    send_item(bpl_pkg::K_LIST, '0, '0);
  endtask

  // Fill to capacity, check refusals, then drain to empty.
  task automatic test_full_list();
    while (held_values.size() < bpl_pkg::DEPTH) begin
      send_item(bpl_pkg::K_INS_BACK, $urandom, '0);
    end
    send_item(bpl_pkg::K_INS_FRONT, 32'sd1, '0);
    send_item(bpl_pkg::K_INS_BACK, 32'sd2, '0);
    send_item(bpl_pkg::K_INS_POS, 32'sd3, 7'd0);
    send_item(bpl_pkg::K_INS_POS, 32'sd4, 7'd1);
    send_item(bpl_pkg::K_COUNT, '0, '0);
    send_item(bpl_pkg::K_LIST, '0, '0);
    send_item(bpl_pkg::K_REM_POS, '0, bpl_pkg::POS_W'(bpl_pkg::DEPTH + 1));
    send_item(bpl_pkg::K_REM_POS, '0, bpl_pkg::POS_W'(bpl_pkg::DEPTH));
    send_item(bpl_pkg::K_INS_POS, VAL_MAX, bpl_pkg::POS_W'(bpl_pkg::DEPTH));
    send_item(bpl_pkg::K_REM_POS, '0, 7'd1);
    while (held_values.size() > 0) begin
      send_item((held_values.size() % 2) ? bpl_pkg::K_REM_BACK : bpl_pkg::K_REM_FRONT,
                '0, '0);
    end
    send_item(bpl_pkg::K_REM_POS, '0, 7'd0);
    send_item(bpl_pkg::K_LIST, '0, '0);
  endtask

  // Random traffic in bursts, swinging the fill level between empty and full.
  task automatic test_random_traffic(input int items);
    bpl_pkg::kind_t k;
    int burst_left;
    int phase_left;
    bit grow;
    burst_left = $urandom_range(1, 20);
    phase_left = $urandom_range(20, 60);
    grow = 1'b1;
    for (int i = 0; i < items; i++) begin
      k = pick_kind(grow);
      send_item(k, pick_value(), pick_position(k));
      phase_left--;
      if (phase_left == 0) begin
        grow = ~grow;
        phase_left = $urandom_range(20, 60);
      end
      burst_left--;
      if (burst_left == 0) begin
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_position_edges();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS);
    start <= 1'b0;
    // Let the last results drain, then allow a few quiet cycles.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
